// File: rtl/absnd_pkg.sv
package absnd_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int QADDR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int PAYLOAD_BYTES = 20;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int SUM_W         = $clog2(PAYLOAD_BYTES * 255 + 1);
    localparam int TIMEOUT_W     = 16;
    localparam int CKS_W         = 16;
    localparam int TIMEOUT_RESET = 15;

    localparam int S_TDATA_W = 192;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 184;
    localparam int M_TUSER_W = 5;

    typedef enum logic [1:0] {
        FUNC_MSG  = 2'd0,
        FUNC_ACK  = 2'd1,
        FUNC_TICK = 2'd2
    } func_t;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_SENT        = 4'd1,
        EV_QUEUED      = 4'd2,
        EV_QUEUE_FULL  = 4'd3,
        EV_IDLE        = 4'd4,
        EV_NOT_WAITING = 4'd5,
        EV_CORRUPT     = 4'd6,
        EV_WRONG_ACK   = 4'd7,
        EV_RESENT      = 4'd8
    } event_t;

    typedef struct packed {
        logic [31:0] hi;
        logic [63:0] mid;
        logic [63:0] lo;
    } payload_t;

    // queued message with its byte sum worked out at enqueue time
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        payload_t         pay;
    } qentry_t;

    function automatic logic [SUM_W-1:0] byte_sum(input payload_t p);
        logic [PAYLOAD_W-1:0] flat;
        logic [SUM_W-1:0]     acc;
        flat = p;
        acc  = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            acc = acc + SUM_W'(flat[i*8 +: 8]);
        end
        return acc;
    endfunction

endpackage

// File: rtl/absnd_ram.sv
module absnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/alternating_bit_sender_unit.sv
// stop-and-wait alternating-bit sender, one result item per input item
// the result passes through the input register and then the result register
// throughput: 1 item per cycle while m_tready does not stall the result; the queue ram is written at most once per item
// the head entry is prefetched from the ram's registered read port, with a write bypass
// reset: synchronous active-low aresetn clears control, sequence bit, queue pointers,
// tick count and sets the timeout to 15; ram and payload registers are not cleared
module alternating_bit_sender_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [absnd_pkg::TIMEOUT_W-1:0]      cfg_wr_data,   // retransmit_timeout
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // payload_lo, payload_mid, payload_hi, rx_seq, rx_ack, rx_checksum
    input  logic [absnd_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [absnd_pkg::S_TUSER_W-1:0]      s_tuser,       // func
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tx_seq, tx_checksum, tx_payload_lo, tx_payload_mid, tx_payload_hi, zero pad
    output logic [absnd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [absnd_pkg::M_TUSER_W-1:0]      m_tuser        // tx_valid, event_code
);
    import absnd_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [1:0]        in_func_reg;
    payload_t          in_pay_reg;
    logic [7:0]        in_rx_seq_reg;
    logic [7:0]        in_rx_ack_reg;
    logic [CKS_W-1:0]  in_rx_cks_reg;

    // sender state
    logic                 ready_flag_reg, ready_flag_next;
    logic                 seq_bit_reg, seq_bit_next;
    logic [TIMEOUT_W-1:0] tick_reg, tick_next;
    logic [TIMEOUT_W-1:0] timeout_reg;
    payload_t             last_pay_reg, last_pay_next;
    logic [CKS_W-1:0]     last_cks_reg, last_cks_next;
    logic [QADDR_W-1:0]   head_reg, head_next;
    logic [QCNT_W-1:0]    count_reg, count_next;

    // result register
    logic              out_valid_reg;
    logic              out_tx_valid_reg, out_tx_valid_next;
    logic              out_seq_reg, out_seq_next;
    logic [CKS_W-1:0]  out_cks_reg, out_cks_next;
    payload_t          out_pay_reg, out_pay_next;
    event_t            out_code_reg, out_code_next;

    // queue ram and head bypass
    logic               bypass_valid_reg;
    qentry_t            bypass_entry_reg;
    qentry_t            ram_rdata;
    qentry_t            head_entry;
    qentry_t            wr_entry;
    logic               ram_we;
    logic [QADDR_W-1:0] ram_raddr;
    logic [QADDR_W:0]   tail_wide;
    logic [QADDR_W-1:0] tail;

    logic              advance;
    logic [SUM_W-1:0]  in_sum;
    logic [CKS_W-1:0]  ack_sum;
    logic [TIMEOUT_W-1:0] tick_inc;
    logic              seq_flip;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_sum  = byte_sum(in_pay_reg);
    assign ack_sum = CKS_W'(in_rx_seq_reg) + CKS_W'(in_rx_ack_reg) + CKS_W'(in_sum);
    assign tick_inc = (tick_reg == '1) ? tick_reg : tick_reg + 1'b1;
    assign seq_flip = ~seq_bit_reg;

    assign tail_wide = (QADDR_W+1)'(head_reg) + (QADDR_W+1)'(count_reg);
    assign tail = (tail_wide >= (QADDR_W+1)'(QUEUE_DEPTH))
                ? QADDR_W'(tail_wide - (QADDR_W+1)'(QUEUE_DEPTH))
                : QADDR_W'(tail_wide);

    assign head_entry   = bypass_valid_reg ? bypass_entry_reg : ram_rdata;
    assign wr_entry.sum = in_sum;
    assign wr_entry.pay = in_pay_reg;

    always_comb begin
        ready_flag_next   = ready_flag_reg;
        seq_bit_next      = seq_bit_reg;
        tick_next         = tick_reg;
        last_pay_next     = last_pay_reg;
        last_cks_next     = last_cks_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        ram_we            = 1'b0;
        out_tx_valid_next = 1'b0;
        out_seq_next      = 1'b0;
        out_cks_next      = '0;
        out_pay_next      = '0;
        out_code_next     = EV_NONE;

        unique case (in_func_reg)
            FUNC_MSG: begin
                if (ready_flag_reg) begin
                    last_pay_next     = in_pay_reg;
                    last_cks_next     = CKS_W'(seq_bit_reg) + CKS_W'(in_sum);
                    ready_flag_next   = 1'b0;
                    tick_next         = '0;
                    out_tx_valid_next = 1'b1;
                    out_seq_next      = seq_bit_reg;
                    out_cks_next      = CKS_W'(seq_bit_reg) + CKS_W'(in_sum);
                    out_pay_next      = in_pay_reg;
                    out_code_next     = EV_SENT;
                end else if (count_reg >= QCNT_W'(QUEUE_DEPTH)) begin
                    out_code_next = EV_QUEUE_FULL;
                end else begin
                    ram_we        = advance;
                    count_next    = count_reg + 1'b1;
                    out_code_next = EV_QUEUED;
                end
            end
            FUNC_ACK: begin
                if (ready_flag_reg) begin
                    out_code_next = EV_IDLE;
                end else if (ack_sum != in_rx_cks_reg) begin
                    out_code_next = EV_CORRUPT;
                end else if (in_rx_ack_reg != {7'd0, seq_bit_reg}) begin
                    out_code_next = EV_WRONG_ACK;
                end else begin
                    seq_bit_next = seq_flip;
                    if (count_reg != '0) begin
                        // dequeue head and send it with the flipped bit
                        head_next = (head_reg == QADDR_W'(QUEUE_DEPTH - 1))
                                  ? '0 : head_reg + 1'b1;
                        count_next        = count_reg - 1'b1;
                        last_pay_next     = head_entry.pay;
                        last_cks_next     = CKS_W'(seq_flip) + CKS_W'(head_entry.sum);
                        tick_next         = '0;
                        out_tx_valid_next = 1'b1;
                        out_seq_next      = seq_flip;
                        out_cks_next      = CKS_W'(seq_flip) + CKS_W'(head_entry.sum);
                        out_pay_next      = head_entry.pay;
                        out_code_next     = EV_SENT;
                    end else begin
                        ready_flag_next = 1'b1;
                        tick_next       = '0;
                        out_code_next   = EV_NONE;
                    end
                end
            end
            FUNC_TICK: begin
                if (ready_flag_reg) begin
                    out_code_next = EV_NOT_WAITING;
                end else if (tick_inc >= timeout_reg) begin
                    tick_next         = '0;
                    out_tx_valid_next = 1'b1;
                    out_seq_next      = seq_bit_reg;
                    out_cks_next      = last_cks_reg;
                    out_pay_next      = last_pay_reg;
                    out_code_next     = EV_RESENT;
                end else begin
                    tick_next = tick_inc;
                end
            end
            default: begin
                out_code_next = EV_NONE;
            end
        endcase
    end

    // keep the read port on the head that will be current next cycle
    assign ram_raddr = advance ? head_next : head_reg;

    absnd_ram #(
        .WIDTH ($bits(qentry_t)),
        .DEPTH (QUEUE_DEPTH),
        .AW    (QADDR_W)
    ) u_queue_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (tail),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            ready_flag_reg   <= 1'b1;
            seq_bit_reg      <= 1'b0;
            tick_reg         <= '0;
            head_reg         <= '0;
            count_reg        <= '0;
            timeout_reg      <= TIMEOUT_W'(TIMEOUT_RESET);
            bypass_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                ready_flag_reg <= ready_flag_next;
                seq_bit_reg    <= seq_bit_next;
                tick_reg       <= tick_next;
                head_reg       <= head_next;
                count_reg      <= count_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            // ram returns old data when the head slot is written in the same cycle
            bypass_valid_reg <= ram_we && (tail == ram_raddr);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg   <= s_tuser;
            in_pay_reg    <= s_tdata[PAYLOAD_W-1:0];
            in_rx_seq_reg <= s_tdata[167:160];
            in_rx_ack_reg <= s_tdata[175:168];
            in_rx_cks_reg <= s_tdata[191:176];
        end
        if (advance) begin
            last_pay_reg     <= last_pay_next;
            last_cks_reg     <= last_cks_next;
            out_tx_valid_reg <= out_tx_valid_next;
            out_seq_reg      <= out_seq_next;
            out_cks_reg      <= out_cks_next;
            out_pay_reg      <= out_pay_next;
            out_code_reg     <= out_code_next;
        end
        bypass_entry_reg <= wr_entry;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_pay_reg, out_cks_reg, out_seq_reg};
    assign m_tuser  = {out_code_reg, out_tx_valid_reg};

endmodule

// File: rtl/absnd_checker.sv
module absnd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wr_en,
    input logic [absnd_pkg::TIMEOUT_W-1:0]  cfg_wr_data,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [absnd_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [absnd_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [absnd_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [absnd_pkg::M_TUSER_W-1:0]  m_tuser
);
    import absnd_pkg::*;

    logic [3:0] code;
    assign code = m_tuser[4:1];

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // only send and resend carry a packet
    a_tx_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == ((code == 4'(EV_SENT)) || (code == 4'(EV_RESENT)))))
        else $error("tx flag does not match item code");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
        else $error("packet fields not zero without transmit");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (code <= 4'(EV_RESENT)))
        else $error("item code out of range");

endmodule

bind alternating_bit_sender_unit absnd_checker u_absnd_checker (.*);
